// ===== hdl/scc_pkg.sv =====
package scc_pkg;
  localparam int MaxNodesDefault = 32;
  localparam int RowBits = 32;
  localparam logic [5:0] NodeCountReset = 6'd32;

  typedef struct packed {
    logic [4:0]  source_node;
    logic [31:0] attack_row;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  component_index;
    logic [31:0] member_mask;
    logic [31:0] father_mask;
    logic        last_component;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_FRAME_RD,
    ST_FRAME,
    ST_SCAN,
    ST_POP,
    ST_RETURN,
    ST_EMIT_RD,
    ST_HIT,
    ST_EMIT
  } state_t;
endpackage

// ===== hdl/strongly_connected_components_core.sv =====
// Rows are written while idle; a last row with a nonzero node count starts a search that
// tests one successor bit per cycle, then emission: component k is tested against each
// earlier component as a possible father, with one stored row read per cycle per test.
// Throughput: one graph at a time; busy drops in the cycle of the final component beat.
// Reset (rst, synchronous): node_count returns to 32, out_valid drops, the controller idles.
module strongly_connected_components_core #(
  parameter int MAX_NODES = scc_pkg::MaxNodesDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  scc_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [5:0]        cfg_data,
  output logic              out_valid,
  output scc_pkg::out_item_t out_item
);
  localparam int AW = 5;
  localparam int NodeLimit = (MAX_NODES < scc_pkg::RowBits) ? MAX_NODES : scc_pkg::RowBits;

  // graph memory: one read port, one write port
  logic [31:0] adj_mem [32];
  logic [31:0] adj_q;
  logic [AW-1:0] adj_raddr;
  logic          adj_we;

  logic [5:0]  node_count;
  logic [5:0]  n;
  logic [31:0] keep;

  scc_pkg::state_t state, state_next;

  logic [31:0] visited, on_stk;
  logic [5:0]  vnum [32];
  logic [5:0]  low [32];
  logic [4:0]  nstk [32];
  logic [4:0]  cnode [32];
  logic [5:0]  cnext [32];
  logic [31:0] comp [32];
  logic [5:0]  nsp, csp, vcnt, ctot;
  logic [5:0]  root;
  logic [4:0]  v;
  logic [5:0]  j;
  logic [31:0] row;
  logic [5:0]  k, m, b;
  logic [31:0] hits, fathers;

  assign cfg_ready = (state == scc_pkg::ST_IDLE);
  assign busy = (state != scc_pkg::ST_IDLE);
  assign n = (node_count > 6'(NodeLimit)) ? 6'(NodeLimit) : node_count;
  assign keep = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
  assign adj_we = start && !busy;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[in_item.source_node] <= in_item.attack_row;
    adj_q <= adj_mem[adj_raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      scc_pkg::ST_IDLE:
        if (adj_we && in_item.last_row && n != 6'd0) state_next = scc_pkg::ST_ROOT;
      scc_pkg::ST_ROOT:
        if (root >= n) state_next = (ctot == 6'd0) ? scc_pkg::ST_IDLE : scc_pkg::ST_EMIT_RD;
        else if (!visited[root[4:0]]) state_next = scc_pkg::ST_FRAME_RD;
      scc_pkg::ST_FRAME_RD: state_next = scc_pkg::ST_FRAME;
      scc_pkg::ST_FRAME:    state_next = scc_pkg::ST_SCAN;
      scc_pkg::ST_SCAN:
        if (j >= n) state_next = scc_pkg::ST_POP;
        else if (row[j[4:0]] && !visited[j[4:0]]) state_next = scc_pkg::ST_FRAME_RD;
      scc_pkg::ST_POP:
        if (low[v] != vnum[v]) state_next = scc_pkg::ST_RETURN;
        else if (nstk[nsp[4:0]-5'd1] == v || nsp == 6'd1) state_next = scc_pkg::ST_RETURN;
      scc_pkg::ST_RETURN:
        state_next = (csp == 6'd1) ? scc_pkg::ST_ROOT : scc_pkg::ST_FRAME_RD;
      scc_pkg::ST_EMIT_RD: state_next = (m == k) ? scc_pkg::ST_EMIT : scc_pkg::ST_HIT;
      scc_pkg::ST_HIT:
        if (b >= n) state_next = scc_pkg::ST_EMIT_RD;
      scc_pkg::ST_EMIT:
        state_next = (k + 6'd1 == ctot) ? scc_pkg::ST_IDLE : scc_pkg::ST_EMIT_RD;
      default: state_next = scc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    adj_raddr = v;
    if (state == scc_pkg::ST_HIT || state == scc_pkg::ST_EMIT_RD) adj_raddr = b[4:0];
    if (state == scc_pkg::ST_FRAME_RD) adj_raddr = cnode[csp[4:0]-5'd1];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= scc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) node_count <= scc_pkg::NodeCountReset;
    else if (cfg_valid && cfg_ready) node_count <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= (state == scc_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    case (state)
      scc_pkg::ST_IDLE: begin
        visited <= '0; on_stk <= '0;
        nsp <= '0; csp <= '0; vcnt <= '0; ctot <= '0; root <= '0;
        k <= '0; m <= '0; b <= '0; fathers <= '0; hits <= '0;
      end
      scc_pkg::ST_ROOT:
        if (root < n) begin
          if (!visited[root[4:0]]) begin
            visited[root[4:0]] <= 1'b1;
            on_stk[root[4:0]] <= 1'b1;
            vnum[root[4:0]] <= vcnt; low[root[4:0]] <= vcnt;
            vcnt <= vcnt + 6'd1;
            nstk[nsp[4:0]] <= root[4:0]; nsp <= nsp + 6'd1;
            cnode[csp[4:0]] <= root[4:0]; cnext[csp[4:0]] <= '0; csp <= csp + 6'd1;
          end
          root <= root + 6'd1;
        end
      scc_pkg::ST_FRAME_RD: begin
        v <= cnode[csp[4:0]-5'd1];
        j <= cnext[csp[4:0]-5'd1];
      end
      scc_pkg::ST_FRAME: row <= adj_q & keep;
      scc_pkg::ST_SCAN:
        if (j < n) begin
          j <= j + 6'd1;
          if (row[j[4:0]]) begin
            cnext[csp[4:0]-5'd1] <= j + 6'd1;
            if (!visited[j[4:0]]) begin
              visited[j[4:0]] <= 1'b1;
              on_stk[j[4:0]] <= 1'b1;
              vnum[j[4:0]] <= vcnt; low[j[4:0]] <= vcnt;
              vcnt <= vcnt + 6'd1;
              nstk[nsp[4:0]] <= j[4:0]; nsp <= nsp + 6'd1;
              cnode[csp[4:0]] <= j[4:0]; cnext[csp[4:0]] <= '0; csp <= csp + 6'd1;
            end else if (on_stk[j[4:0]] && vnum[j[4:0]] < low[v]) begin
              low[v] <= vnum[j[4:0]];
            end
          end
        end else begin
          comp[ctot[4:0]] <= '0;
        end
      scc_pkg::ST_POP:
        if (low[v] == vnum[v]) begin
          nsp <= nsp - 6'd1;
          on_stk[nstk[nsp[4:0]-5'd1]] <= 1'b0;
          comp[ctot[4:0]] <= comp[ctot[4:0]] | (32'd1 << nstk[nsp[4:0]-5'd1]);
          if (nstk[nsp[4:0]-5'd1] == v || nsp == 6'd1) ctot <= ctot + 6'd1;
        end
      scc_pkg::ST_RETURN: begin
        csp <= csp - 6'd1;
        if (csp != 6'd1 && low[v] < low[cnode[csp[4:0]-5'd2]])
          low[cnode[csp[4:0]-5'd2]] <= low[v];
      end
      scc_pkg::ST_EMIT_RD: begin
        hits <= '0;
        b <= '0;
      end
      scc_pkg::ST_HIT:
        // registered read: row b-1 is in adj_q while b advances
        if (b < n) begin
          b <= b + 6'd1;
          if (b != 6'd0 && comp[ctot[4:0]-5'd1-m[4:0]][b[4:0]-5'd1])
            hits <= hits | (adj_q & keep);
        end else begin
          if (comp[ctot[4:0]-5'd1-m[4:0]][b[4:0]-5'd1])
            hits <= hits | (adj_q & keep);
          if (((hits | (comp[ctot[4:0]-5'd1-m[4:0]][b[4:0]-5'd1] ? (adj_q & keep) : 32'd0))
               & comp[ctot[4:0]-5'd1-k[4:0]]) != '0)
            fathers <= fathers | (32'd1 << m[4:0]);
          m <= m + 6'd1;
        end
      scc_pkg::ST_EMIT: begin
        out_item.component_index <= k[4:0];
        out_item.member_mask <= comp[ctot[4:0]-5'd1-k[4:0]];
        out_item.father_mask <= fathers;
        out_item.last_component <= (k + 6'd1 == ctot);
        k <= k + 6'd1; m <= '0; fathers <= '0;
      end
      default: ;
    endcase
  end
endmodule

// ===== hdl/scc_checker.sv =====
module scc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic out_valid,
  input scc_pkg::out_item_t out_item
);
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !busy)
    else $error("cfg beat while busy");
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> $past(busy))
    else $error("result beat without search");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last_component |-> !busy)
    else $error("busy after last beat");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("search without start");
endmodule

bind strongly_connected_components_core scc_checker u_scc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready), .out_valid(out_valid), .out_item(out_item)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int SettleCycles = 2500;
  localparam int TailCycles = 2500;

  typedef struct {
    bit                 is_cfg;
    logic [5:0]         count;
    scc_pkg::in_item_t  row_item;
    int                 gap;
  } job_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  scc_pkg::in_item_t  in_item = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = '0;
  logic       out_valid;
  scc_pkg::out_item_t out_item;

  job_t       jobs[$];
  scc_pkg::out_item_t pending_components[$];
  logic [31:0] graph_rows[32];
  logic [5:0] node_count_q = scc_pkg::NodeCountReset;
  int         fail_count = 0;
  int         settle = 0;

  strongly_connected_components_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store the row; on a last row run Tarjan and queue one result per component.
  function automatic void predict_components(scc_pkg::in_item_t it);
    int n, nsp, csp, total, v, j, w, t, p, k, m, b;
    logic [31:0] keep, row, members, fathers, hits;
    int vis[32], low[32], nstk[32], cnode[32], cnext[32];
    bit seen[32], onst[32];
    bit descended;
    logic [31:0] comp[32];
    scc_pkg::out_item_t r;
    graph_rows[it.source_node] = it.attack_row;
    if (!it.last_row) return;
    n = (node_count_q > 32) ? 32 : int'(node_count_q);
    if (n == 0) return;
    keep = (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 1);
    nsp = 0; csp = 0; total = 0; t = 0;
    for (int i = 0; i < 32; i++) begin
      seen[i] = 0; onst[i] = 0;
    end
    t = 0;
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root] = 1; vis[root] = t; low[root] = t; t++;
      nstk[nsp++] = root; onst[root] = 1;
      cnode[csp] = root; cnext[csp] = 0; csp++;
      while (csp > 0) begin
        v = cnode[csp-1];
        j = cnext[csp-1];
        row = graph_rows[v] & keep;
        descended = 0;
        while (j < n) begin
          w = j;
          j++;
          if (!row[w]) continue;
          cnext[csp-1] = j;
          if (!seen[w]) begin
            seen[w] = 1; vis[w] = t; low[w] = t; t++;
            nstk[nsp++] = w; onst[w] = 1;
            cnode[csp] = w; cnext[csp] = 0; csp++;
            descended = 1;
            break;
          end
          if (onst[w] && vis[w] < low[v]) low[v] = vis[w];
        end
        if (descended) continue;
        cnext[csp-1] = n;
        if (low[v] == vis[v]) begin
          members = '0;
          do begin
            nsp--;
            w = nstk[nsp];
            onst[w] = 0;
            members[w] = 1'b1;
          end while (w != v && nsp > 0);
          comp[total++] = members;
        end
        csp--;
        if (csp > 0) begin
          p = cnode[csp-1];
          if (low[v] < low[p]) low[p] = low[v];
        end
      end
    end
    for (k = 0; k < total; k++) begin
      members = comp[total-1-k];
      fathers = '0;
      for (m = 0; m < k; m++) begin
        hits = '0;
        for (b = 0; b < n; b++)
          if (comp[total-1-m][b]) hits |= graph_rows[b] & keep;
        if ((hits & members) != 0) fathers[m] = 1'b1;
      end
      r.component_index = k[4:0];
      r.member_mask = members;
      r.father_mask = fathers;
      r.last_component = (k + 1 == total);
      pending_components.insert(pending_components.size(), r);
    end
  endfunction

  // Driver: one beat per job, config writes only once the block has drained.
  always @(posedge clk) begin
    logic go, cv;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      settle = 0;
    end else begin
      go = start;
      cv = cfg_valid;
      if (start && !busy) begin
        predict_components(in_item);
        go = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        node_count_q = cfg_data;
        cv = 1'b0;
      end
      if (!go && !cv && jobs.size() > 0) begin
        if (jobs[0].is_cfg) begin
          if (pending_components.size() == 0 && !busy) begin
            if (settle >= SettleCycles) begin
              cfg_data <= jobs[0].count;
              cv = 1'b1;
              void'(jobs.pop_front());
              settle = 0;
            end else begin
              settle++;
            end
          end else begin
            settle = 0;
          end
        end else if (jobs[0].gap > 0) begin
          jobs[0].gap--;
        end else begin
          in_item <= jobs[0].row_item;
          go = 1'b1;
          void'(jobs.pop_front());
        end
      end
      start <= go;
      cfg_valid <= cv;
    end
  end

  // Monitor: every strobed beat must match the oldest expected component.
  always @(posedge clk) begin
    scc_pkg::out_item_t e;
    if (!rst && out_valid) begin
      if (pending_components.size() == 0) begin
        $error("unexpected component beat %h", out_item);
        fail_count++;
      end else begin
        e = pending_components.pop_front();
        if (out_item.component_index !== e.component_index) begin
          $error("component_index exp %0d got %0d", e.component_index,
                 out_item.component_index);
          fail_count++;
        end
        if (out_item.member_mask !== e.member_mask) begin
          $error("member_mask exp %h got %h", e.member_mask, out_item.member_mask);
          fail_count++;
        end
        if (out_item.father_mask !== e.father_mask) begin
          $error("father_mask exp %h got %h", e.father_mask, out_item.father_mask);
          fail_count++;
        end
        if (out_item.last_component !== e.last_component) begin
          $error("last_component exp %0d got %0d", e.last_component,
                 out_item.last_component);
          fail_count++;
        end
      end
    end
  end

  bit gaps_on = 1'b1;
  int row_total = 0;

  function automatic void add_row(int src, logic [31:0] row, bit last);
    job_t jb;
    jb.is_cfg = 0;
    jb.count = '0;
    jb.row_item.source_node = src[4:0];
    jb.row_item.attack_row = row;
    jb.row_item.last_row = last;
    jb.gap = gaps_on ? $urandom_range(0, 11) : 0;
    jobs.insert(jobs.size(), jb);
    row_total++;
  endfunction

  function automatic void add_cfg(logic [5:0] c);
    job_t jb;
    jb.is_cfg = 1;
    jb.count = c;
    jb.row_item = '0;
    jb.gap = 0;
    jobs.insert(jobs.size(), jb);
  endfunction

  function automatic logic [31:0] random_row();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  // Write every row in use in shuffled order with some noise rows, then a last row.
  function automatic void add_graph(int n);
    int order[$];
    int tmp, idx;
    for (int i = 0; i < n; i++) order.insert(order.size(), i);
    order.shuffle();
    foreach (order[i]) begin
      add_row(order[i], random_row(), 1'b0);
      if ($urandom_range(0, 9) == 0) add_row($urandom_range(0, 31), random_row(), 1'b0);
    end
    idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
    tmp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : idx;
    if (tmp >= n && n < 32 && tmp >= 32) tmp = idx;
    add_row(tmp, random_row(), 1'b1);
  endfunction

  initial begin
    logic [5:0] counts[$];
    int n;
    counts = '{6'd1, 6'd2, 6'd7, 6'd32, 6'd63, 6'd0, 6'd12, 6'd40, 6'd20, 6'd5,
               6'd32, 6'd3, 6'd17, 6'd9, 6'd25};
    // directed: four nodes, isolated, complete with self attack, chain, ring
    add_cfg(6'd4);
    for (int i = 0; i < 4; i++) add_row(i, 32'h0, i == 3);
    for (int i = 0; i < 4; i++) add_row(i, 32'hFFFF_FFFF, i == 3);
    for (int i = 0; i < 4; i++) add_row(i, 32'h1 << (i + 1), i == 3);
    for (int i = 0; i < 4; i++) add_row(i, 32'h1 << ((i + 1) % 4), i == 3);
    add_row(31, 32'hAAAA_5555, 1'b0);
    add_row(2, 32'h0000_0003, 1'b1);
    add_cfg(6'd0);
    add_row(0, 32'h1, 1'b1);
    add_row(17, 32'h8000_0000, 1'b1);
    row_total = 0;
    while (row_total < 330) begin
      foreach (counts[c]) begin
        if (row_total >= 330) break;
        gaps_on = ($urandom_range(0, 3) != 0);
        add_cfg(counts[c]);
        n = (counts[c] > 32) ? 32 : int'(counts[c]);
        repeat ((n > 16) ? 1 : 3) add_graph(n);
      end
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (jobs.size() == 0 && !start && !cfg_valid && pending_components.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending_components.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
